[design/pesb_pkg.sv]
// Shared types and constants for the positional edit sequence buffer.
// No dependencies; imported by every module of the block.
package pesb_pkg;

	// Field widths of the request and result items
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 7;
	localparam int SYM_W     = 8;
	localparam int STAT_W    = 2;
	localparam int LEN_OUT_W = 7;
	// tdata widths: position + symbol in, out_symbol + cur_length out, byte padded
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 16;

	// Request function codes; codes 6 and 7 are not defined
	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND  = 3'd0,
		FN_INSERT  = 3'd1,
		FN_DELETE  = 3'd2,
		FN_REPLACE = 3'd3,
		FN_DUMP    = 3'd4,
		FN_CLEAR   = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Per-cell update applied across the whole store at once
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_APPEND  = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DELETE  = 3'd3,
		OP_REPLACE = 3'd4,
		OP_ROTATE  = 3'd5,
		OP_CLEAR   = 3'd6
	} cell_op_t;

	// Controller -> datapath
	typedef struct packed {
		cell_op_t op;
		logic     load_out;
		logic     from_cell;
		logic     last;
		status_t  status;
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic                 full;
		logic                 pos_le_len;
		logic                 pos_lt_len;
		logic                 empty;
		logic [LEN_OUT_W-1:0] len;
	} dp_stat_t;

endpackage

[design/pesb_datapath.sv]
// Datapath: shifting symbol cells, length register and result register.
// Depends on pesb_pkg; driven by pesb_ctrl through dp_cmd_t.
module pesb_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pesb_pkg::POS_W-1:0]      pos,
	input  logic [pesb_pkg::SYM_W-1:0]      symbol,
	input  pesb_pkg::dp_cmd_t               cmd,
	output pesb_pkg::dp_stat_t              stat,
	output logic [pesb_pkg::SYM_W-1:0]      out_symbol,
	output logic                            is_last,
	output pesb_pkg::status_t               status,
	output logic [pesb_pkg::LEN_OUT_W-1:0]  cur_length
);
	import pesb_pkg::*;

	localparam int LEN_W = $clog2(DEPTH + 1);

	logic [SYM_W-1:0]     cells_q [DEPTH];
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_d;
	logic [SYM_W-1:0]     sym_q;
	logic                 last_q;
	status_t              status_q;
	logic [LEN_OUT_W-1:0] len_out_q;

	always_comb begin
		unique case (cmd.op)
			OP_APPEND, OP_INSERT: len_d = len_q + LEN_W'(1);
			OP_DELETE:            len_d = len_q - LEN_W'(1);
			OP_CLEAR:             len_d = '0;
			default:              len_d = len_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			len_q <= len_d;
		end
	end

	assign stat.full       = (len_q == LEN_W'(DEPTH));
	assign stat.pos_le_len = (pos <= POS_W'(len_q));
	assign stat.pos_lt_len = (pos < POS_W'(len_q));
	assign stat.empty      = (len_q == '0);
	assign stat.len        = LEN_OUT_W'(len_q);

	// Each cell sees only its neighbors, cell 0 (rotate wrap), the length and the request.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [SYM_W-1:0] up;
		logic [SYM_W-1:0] dn;
		logic             at_pos;
		logic             above_pos;
		logic             at_end;
		logic             at_tail;

		if (g < DEPTH - 1) begin : g_up
			assign up = cells_q[g+1];
		end else begin : g_up_edge
			assign up = cells_q[g];
		end
		if (g > 0) begin : g_dn
			assign dn = cells_q[g-1];
		end else begin : g_dn_edge
			assign dn = cells_q[g];
		end

		assign at_pos    = (POS_W'(g) == pos);
		assign above_pos = (POS_W'(g) > pos);
		assign at_end    = (LEN_W'(g) == len_q);
		assign at_tail   = (LEN_W'(g + 1) == len_q);

		always_ff @(posedge clk) begin
			unique case (cmd.op)
				OP_APPEND: begin
					if (at_end) cells_q[g] <= symbol;
				end
				OP_INSERT: begin
					if (above_pos) cells_q[g] <= dn;
					else if (at_pos) cells_q[g] <= symbol;
				end
				OP_DELETE: begin
					if (above_pos || at_pos) cells_q[g] <= up;
				end
				OP_REPLACE: begin
					if (at_pos) cells_q[g] <= symbol;
				end
				OP_ROTATE: begin
					cells_q[g] <= at_tail ? cells_q[0] : up;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register; valid flag lives in the controller
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sym_q     <= cmd.from_cell ? cells_q[0] : '0;
			last_q    <= cmd.last;
			status_q  <= cmd.status;
			len_out_q <= LEN_OUT_W'(len_d);
		end
	end

	assign out_symbol = sym_q;
	assign is_last    = last_q;
	assign status     = status_q;
	assign cur_length = len_out_q;

endmodule

[design/pesb_ctrl.sv]
// Controller: request decode, dump sequencing and result valid flag.
// Depends on pesb_pkg; commands pesb_datapath through dp_cmd_t.
module pesb_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  pesb_pkg::func_t    func,
	input  pesb_pkg::dp_stat_t stat,
	output pesb_pkg::dp_cmd_t  cmd,
	output logic               m_tvalid,
	input  logic               m_tready
);
	import pesb_pkg::*;

	localparam int CNT_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             valid_q;
	logic             out_free;
	logic             accept;
	logic             dump_last;

	assign out_free  = !valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign dump_last = ((LEN_OUT_W'(cnt_q) + LEN_OUT_W'(1)) == stat.len);

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.load_out  = 1'b0;
		cmd.from_cell = 1'b0;
		cmd.last      = 1'b1;
		cmd.status    = ST_OK;
		state_d       = state_q;
		cnt_d         = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_out = 1'b1;
					unique case (func)
						FN_APPEND: begin
							if (stat.full) cmd.status = ST_FULL;
							else cmd.op = OP_APPEND;
						end
						FN_INSERT: begin
							priority if (!stat.pos_le_len) cmd.status = ST_IGNORED;
							else if (stat.full) cmd.status = ST_FULL;
							else cmd.op = OP_INSERT;
						end
						FN_DELETE: begin
							if (!stat.pos_lt_len) cmd.status = ST_IGNORED;
							else cmd.op = OP_DELETE;
						end
						FN_REPLACE: begin
							if (!stat.pos_lt_len) cmd.status = ST_IGNORED;
							else cmd.op = OP_REPLACE;
						end
						FN_DUMP: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.load_out = 1'b0;
								state_d      = S_DUMP;
								cnt_d        = '0;
							end
						end
						FN_CLEAR: cmd.op = OP_CLEAR;
						default:  cmd.status = ST_IGNORED;
					endcase
				end
			end
			S_DUMP: begin
				if (out_free) begin
					cmd.load_out  = 1'b1;
					cmd.from_cell = 1'b1;
					cmd.op        = OP_ROTATE;
					cmd.last      = dump_last;
					cnt_d         = cnt_q + CNT_W'(1);
					if (dump_last) begin
						state_d = S_IDLE;
						cnt_d   = '0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;

endmodule

[design/positional_edit_sequence_buffer.sv]
// Top level of the positional edit sequence buffer (indexed insert/delete list).
// Depends on pesb_pkg, pesb_ctrl and pesb_datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: position, symbol; s_tuser: func
//  m_*     | out | m_tvalid/m_tready  | m_tdata: out_symbol, cur_length;
//          |     |                    | m_tuser: status; m_tlast: is_last
//
//  Append, insert, delete, replace and clear complete at the accepting edge:
//  insert and delete shift the whole store at once, each cell loading from its
//  neighbor, and one status result goes into the output register at that edge.
//  A dump of L symbols rotates the store by one cell per cycle while the output
//  is free, and cell 0 feeds the output, so the store is back in order after the last one.
//  Input is held off while a dump streams and while a result waits on a low
//  m_tready; a stalled m_tready stalls the dump.
//  Reset clears the length and control state; the cells are not reset.
module positional_edit_sequence_buffer #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pesb_pkg::S_DATA_W-1:0]    s_tdata,  // [6:0] position, [14:7] symbol
	input  logic [pesb_pkg::FUNC_W-1:0]      s_tuser,  // [2:0] func
	// result
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pesb_pkg::M_DATA_W-1:0]    m_tdata,  // [7:0] out_symbol, [14:8] cur_length
	output logic [pesb_pkg::STAT_W-1:0]      m_tuser,  // [1:0] status
	output logic                             m_tlast   // is_last
);
	import pesb_pkg::*;

	localparam int SYM_LO = POS_W;
	localparam int S_USED = POS_W + SYM_W;
	localparam int M_USED = SYM_W + LEN_OUT_W;

	func_t                func;
	logic [POS_W-1:0]     position;
	logic [SYM_W-1:0]     symbol;
	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [SYM_W-1:0]     out_symbol;
	logic                 is_last;
	status_t              status;
	logic [LEN_OUT_W-1:0] cur_length;

	// Unpack the request; the pad bits above S_USED are ignored
	assign func     = func_t'(s_tuser);
	assign position = s_tdata[POS_W-1:0];
	assign symbol   = s_tdata[SYM_LO +: SYM_W];

	pesb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.func    (func),
		.stat    (stat),
		.cmd     (cmd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	pesb_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos       (position),
		.symbol    (symbol),
		.cmd       (cmd),
		.stat      (stat),
		.out_symbol(out_symbol),
		.is_last   (is_last),
		.status    (status),
		.cur_length(cur_length)
	);

	// Pack the result word, zero fill to whole bytes
	assign m_tdata = {{(M_DATA_W - M_USED){1'b0}}, cur_length, out_symbol};
	assign m_tuser = status;
	assign m_tlast = is_last;

endmodule

[design/pesb_checker.sv]
// Port-level checks for positional_edit_sequence_buffer, bound to the top level.
// Depends on pesb_pkg for status codes and field widths.
module pesb_checker #(
	parameter int DEPTH = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pesb_pkg::M_DATA_W-1:0] m_tdata,
	input logic [pesb_pkg::STAT_W-1:0]   m_tuser,
	input logic                          m_tlast
);
	import pesb_pkg::*;

	localparam int LEN_LO = SYM_W;

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// Length never exceeds the store depth
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[LEN_LO +: LEN_OUT_W] <= LEN_OUT_W'(DEPTH)))
		else $error("cur_length beyond depth");

	// Non-ok status is a single-result request with a zero symbol
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata[SYM_W-1:0] == '0))
		else $error("non-ok result not final or has symbol");

	// No new request is taken in the middle of a dump
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken during dump");

endmodule

bind positional_edit_sequence_buffer pesb_checker #(
	.DEPTH(DEPTH)
) u_pesb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
